/* design/lltd_pkg.sv */
// ----------------------------------------------------------------------------
// lltd_pkg: shared types and constants of the ticket dispatcher
// Request and status codes, the sequencer states and the slot word layout.
// ----------------------------------------------------------------------------
package lltd_pkg;

   localparam int MAX_WORKERS_DEF = 16;
   localparam int MAX_SLOTS_DEF   = 8;

   localparam int CAP_W   = 4;
   localparam int ID_W    = 16;
   localparam int PRIO_W  = 8;
   localparam int TYPE_W  = 2;
   localparam int STAT_W  = 3;
   localparam int WIDX_W  = 4;
   localparam int WLOAD_W = 4;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 4'd5;

   localparam logic [TYPE_W-1:0] REQ_ADD     = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ASSIGN  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RESOLVE = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_SPARE   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_JOB    = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_WORKER = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOTHING   = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } slot_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [WIDX_W-1:0]  worker_index;
      logic [ID_W-1:0]    out_job_id;
      logic [PRIO_W-1:0]  out_job_priority;
      logic [WLOAD_W-1:0] worker_load;
   } result_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD,
      S_LD_RD,
      S_LD_EV,
      S_SL_RD,
      S_SL_EV,
      S_NEXT_W,
      S_ASG_END,
      S_RES_END,
      S_SH_RD,
      S_SH_EV,
      S_FIN_WR,
      S_DONE
   } state_type;

endpackage

/* design/lltd_req_if.sv */
// ----------------------------------------------------------------------------
// lltd_req_if: request channel of the ticket dispatcher
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface lltd_req_if;
   logic                           valid;
   logic                           ready;
   logic [lltd_pkg::TYPE_W-1:0]    req_type;
   logic                           job_pending;
   logic [lltd_pkg::ID_W-1:0]      job_id;
   logic [lltd_pkg::PRIO_W-1:0]    job_priority;

   modport source (output valid, req_type, job_pending, job_id, job_priority,
                   input ready);
   modport sink   (input valid, req_type, job_pending, job_id, job_priority,
                   output ready);
endinterface

/* design/lltd_rsp_if.sv */
// ----------------------------------------------------------------------------
// lltd_rsp_if: response channel of the ticket dispatcher
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface lltd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lltd_pkg::STAT_W-1:0]    status;
   logic [lltd_pkg::WIDX_W-1:0]    worker_index;
   logic [lltd_pkg::ID_W-1:0]      out_job_id;
   logic [lltd_pkg::PRIO_W-1:0]    out_job_priority;
   logic [lltd_pkg::WLOAD_W-1:0]   worker_load;

   modport source (output valid, status, worker_index, out_job_id,
                   out_job_priority, worker_load, input ready);
   modport sink   (input valid, status, worker_index, out_job_id,
                   out_job_priority, worker_load, output ready);
endinterface

/* design/lltd_store.sv */
// ----------------------------------------------------------------------------
// lltd_store: worker load and job slot memories
// Two single-write, single-read memories with registered read data.
// ----------------------------------------------------------------------------
module lltd_store #(
   parameter int MAX_WORKERS = lltd_pkg::MAX_WORKERS_DEF,
   parameter int MAX_SLOTS   = lltd_pkg::MAX_SLOTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  load_we,
   input  logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] load_waddr,
   input  logic [$clog2(MAX_SLOTS+1)-1:0]        load_wdata,
   input  logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] load_raddr,
   output logic [$clog2(MAX_SLOTS+1)-1:0]        load_rdata,
   input  logic                                  slot_we,
   input  logic [((MAX_WORKERS*MAX_SLOTS > 1) ?
                  $clog2(MAX_WORKERS*MAX_SLOTS) : 1)-1:0] slot_waddr,
   input  lltd_pkg::slot_type                    slot_wdata,
   input  logic [((MAX_WORKERS*MAX_SLOTS > 1) ?
                  $clog2(MAX_WORKERS*MAX_SLOTS) : 1)-1:0] slot_raddr,
   output lltd_pkg::slot_type                    slot_rdata
);

   logic [$clog2(MAX_SLOTS+1)-1:0] load_mem [MAX_WORKERS];
   lltd_pkg::slot_type             slot_mem [MAX_WORKERS*MAX_SLOTS];

   always_ff @(posedge clock) begin
      if (load_we) begin
         load_mem[load_waddr] <= load_wdata;
      end
      load_rdata <= load_mem[load_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rdata <= slot_mem[slot_raddr];
   end

endmodule

/* design/least_loaded_ticket_dispatcher.sv */
// ----------------------------------------------------------------------------
// least_loaded_ticket_dispatcher: worker table with least-loaded dispatch
// Sequencer over a load memory and a job slot memory.
// ----------------------------------------------------------------------------
// The dispatcher keeps a table of workers, each holding an ordered list of
// jobs. An add beat registers a worker, an assign beat places a job on the
// first worker with the smallest load below the capacity register, and a
// resolve beat removes and returns the first job of highest priority. One
// request is worked on at a time and each gives exactly one result beat.
// Each memory read is split into an address state and a state that
// evaluates the registered data. A new request is taken as soon as the
// sequencer is idle, even while the previous result beat still waits in
// the output register. The capacity register is written through csr_wr_en
// and csr_wr_data and should be changed only while idle.
module least_loaded_ticket_dispatcher #(
   parameter int MAX_WORKERS = lltd_pkg::MAX_WORKERS_DEF,
   parameter int MAX_SLOTS   = lltd_pkg::MAX_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   lltd_req_if.sink                    req_bus,
   lltd_rsp_if.source                  rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [lltd_pkg::CAP_W-1:0]  csr_wr_data
);

   // Index widths follow from the table geometry.
   localparam int WW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int AW  = (MAX_WORKERS*MAX_SLOTS > 1) ? $clog2(MAX_WORKERS*MAX_SLOTS) : 1;
   localparam int WCW = $clog2(MAX_WORKERS+1);
   localparam int LW  = $clog2(MAX_SLOTS+1);
   localparam int CW  = (LW > lltd_pkg::CAP_W) ? LW : lltd_pkg::CAP_W;

   lltd_pkg::state_type state_ff, state_in;

   logic [lltd_pkg::CAP_W-1:0]  capacity_ff;
   logic [WCW-1:0]              wcount_ff;
   logic [lltd_pkg::TYPE_W-1:0] op_ff;
   logic                        pending_ff;
   logic [lltd_pkg::ID_W-1:0]   jid_ff;
   logic [lltd_pkg::PRIO_W-1:0] jprio_ff;

   // Scan position and the best candidate found so far.
   logic [WCW-1:0]              w_ff;
   logic [LW-1:0]               s_ff;
   logic [LW-1:0]               cld_ff;
   logic                        found_ff;
   logic [WW-1:0]               bw_ff;
   logic [LW-1:0]               bs_ff;
   logic [LW-1:0]               bld_ff;
   logic [lltd_pkg::PRIO_W-1:0] bp_ff;
   logic [lltd_pkg::ID_W-1:0]   bid_ff;

   lltd_pkg::result_type        res_ff;
   lltd_pkg::result_type        out_ff;
   logic                        out_valid_ff;

   // Memory ports.
   logic                        load_we;
   logic [WW-1:0]               load_waddr;
   logic [LW-1:0]               load_wdata;
   logic [LW-1:0]               load_rdata;
   logic                        slot_we;
   logic [AW-1:0]               slot_waddr;
   lltd_pkg::slot_type          slot_wdata;
   logic [AW-1:0]               slot_raddr;
   lltd_pkg::slot_type          slot_rdata;

   logic                        req_take;
   logic                        out_load;
   logic [CW-1:0]               bound;
   logic [LW-1:0]               rd_slots;
   logic [LW-1:0]               s_next;
   logic [LW-1:0]               bs_next;

   lltd_store #(
      .MAX_WORKERS (MAX_WORKERS),
      .MAX_SLOTS   (MAX_SLOTS)
   ) u_store (
      .clock      (clock),
      .load_we    (load_we),
      .load_waddr (load_waddr),
      .load_wdata (load_wdata),
      .load_raddr (w_ff[WW-1:0]),
      .load_rdata (load_rdata),
      .slot_we    (slot_we),
      .slot_waddr (slot_waddr),
      .slot_wdata (slot_wdata),
      .slot_raddr (slot_raddr),
      .slot_rdata (slot_rdata)
   );

   // The effective capacity never exceeds the slots a worker has.
   assign bound = (CW'(capacity_ff) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(capacity_ff);
   // Number of slots of the worker whose load was just read.
   assign rd_slots = (load_rdata > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : load_rdata;
   assign s_next   = s_ff + LW'(1);
   assign bs_next  = bs_ff + LW'(1);

   assign req_take = req_bus.valid && req_bus.ready;
   assign out_load = (state_ff == lltd_pkg::S_DONE) && (!out_valid_ff || rsp_bus.ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lltd_pkg::S_IDLE: begin
            if (req_bus.valid) begin
               unique case (req_bus.req_type)
                  lltd_pkg::REQ_ADD:     state_in = lltd_pkg::S_ADD;
                  lltd_pkg::REQ_ASSIGN:  state_in = (wcount_ff == '0) ?
                                                    lltd_pkg::S_ASG_END : lltd_pkg::S_LD_RD;
                  lltd_pkg::REQ_RESOLVE: state_in = (wcount_ff == '0) ?
                                                    lltd_pkg::S_RES_END : lltd_pkg::S_LD_RD;
                  default:               state_in = lltd_pkg::S_DONE;
               endcase
            end
         end
         lltd_pkg::S_ADD:   state_in = lltd_pkg::S_DONE;
         lltd_pkg::S_LD_RD: state_in = lltd_pkg::S_LD_EV;
         lltd_pkg::S_LD_EV: begin
            if (op_ff == lltd_pkg::REQ_RESOLVE && rd_slots != '0) begin
               state_in = lltd_pkg::S_SL_RD;
            end else begin
               state_in = lltd_pkg::S_NEXT_W;
            end
         end
         lltd_pkg::S_SL_RD: state_in = lltd_pkg::S_SL_EV;
         lltd_pkg::S_SL_EV: state_in = (s_next == cld_ff) ? lltd_pkg::S_NEXT_W : lltd_pkg::S_SL_RD;
         lltd_pkg::S_NEXT_W: begin
            if (w_ff + WCW'(1) == wcount_ff) begin
               state_in = (op_ff == lltd_pkg::REQ_ASSIGN) ? lltd_pkg::S_ASG_END
                                                          : lltd_pkg::S_RES_END;
            end else begin
               state_in = lltd_pkg::S_LD_RD;
            end
         end
         lltd_pkg::S_ASG_END: state_in = lltd_pkg::S_DONE;
         lltd_pkg::S_RES_END: begin
            priority if (!found_ff) begin
               state_in = lltd_pkg::S_DONE;
            end else if (bs_next < bld_ff) begin
               state_in = lltd_pkg::S_SH_RD;
            end else begin
               state_in = lltd_pkg::S_FIN_WR;
            end
         end
         lltd_pkg::S_SH_RD: state_in = lltd_pkg::S_SH_EV;
         lltd_pkg::S_SH_EV: state_in = ((s_next + LW'(1)) < bld_ff) ? lltd_pkg::S_SH_RD
                                                                   : lltd_pkg::S_FIN_WR;
         lltd_pkg::S_FIN_WR: state_in = lltd_pkg::S_DONE;
         lltd_pkg::S_DONE:   state_in = out_load ? lltd_pkg::S_IDLE : lltd_pkg::S_DONE;
         default:            state_in = lltd_pkg::S_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake and memory controls.
   always_comb begin
      req_bus.ready = (state_ff == lltd_pkg::S_IDLE);
      load_we       = 1'b0;
      load_waddr    = bw_ff;
      load_wdata    = '0;
      slot_we       = 1'b0;
      slot_waddr    = AW'(bw_ff) * AW'(MAX_SLOTS) + AW'(s_ff[SW-1:0]);
      slot_wdata    = slot_rdata;
      slot_raddr    = AW'(w_ff[WW-1:0]) * AW'(MAX_SLOTS) + AW'(s_ff[SW-1:0]);
      unique case (state_ff)
         lltd_pkg::S_ADD: begin
            load_we    = (wcount_ff < WCW'(MAX_WORKERS));
            load_waddr = wcount_ff[WW-1:0];
         end
         lltd_pkg::S_ASG_END: begin
            load_we         = found_ff && pending_ff;
            load_wdata      = bld_ff + LW'(1);
            slot_we         = found_ff && pending_ff;
            slot_waddr      = AW'(bw_ff) * AW'(MAX_SLOTS) + AW'(bld_ff[SW-1:0]);
            slot_wdata.id   = jid_ff;
            slot_wdata.prio = jprio_ff;
         end
         lltd_pkg::S_SH_RD: begin
            slot_raddr = AW'(bw_ff) * AW'(MAX_SLOTS) + AW'(s_next[SW-1:0]);
         end
         lltd_pkg::S_SH_EV: begin
            slot_we = 1'b1;
         end
         lltd_pkg::S_FIN_WR: begin
            load_we    = 1'b1;
            load_wdata = bld_ff - LW'(1);
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lltd_pkg::S_IDLE;
         capacity_ff  <= lltd_pkg::CAPACITY_RESET;
         wcount_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (state_ff == lltd_pkg::S_ADD && wcount_ff < WCW'(MAX_WORKERS)) begin
            wcount_ff <= wcount_ff + WCW'(1);
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= res_ff;
      end
      unique case (state_ff)
         lltd_pkg::S_IDLE: begin
            if (req_take) begin
               op_ff      <= req_bus.req_type;
               pending_ff <= req_bus.job_pending;
               jid_ff     <= req_bus.job_id;
               jprio_ff   <= req_bus.job_priority;
               w_ff       <= '0;
               found_ff   <= 1'b0;
               res_ff     <= '0;
            end
         end
         lltd_pkg::S_ADD: begin
            if (wcount_ff < WCW'(MAX_WORKERS)) begin
               res_ff.status       <= lltd_pkg::ST_OK;
               res_ff.worker_index <= lltd_pkg::WIDX_W'(wcount_ff);
            end else begin
               res_ff.status <= lltd_pkg::ST_FULL;
            end
         end
         lltd_pkg::S_LD_EV: begin
            if (op_ff == lltd_pkg::REQ_ASSIGN) begin
               // Strictly smaller keeps the first of equal loads.
               if (CW'(load_rdata) < bound && (!found_ff || load_rdata < bld_ff)) begin
                  found_ff <= 1'b1;
                  bw_ff    <= w_ff[WW-1:0];
                  bld_ff   <= load_rdata;
               end
            end
            cld_ff <= rd_slots;
            s_ff   <= '0;
         end
         lltd_pkg::S_SL_EV: begin
            if (!found_ff || slot_rdata.prio > bp_ff) begin
               found_ff <= 1'b1;
               bw_ff    <= w_ff[WW-1:0];
               bs_ff    <= s_ff;
               bld_ff   <= cld_ff;
               bp_ff    <= slot_rdata.prio;
               bid_ff   <= slot_rdata.id;
            end
            s_ff <= s_next;
         end
         lltd_pkg::S_NEXT_W: begin
            w_ff <= w_ff + WCW'(1);
         end
         lltd_pkg::S_ASG_END: begin
            priority if (!found_ff) begin
               res_ff.status <= lltd_pkg::ST_NO_WORKER;
            end else if (!pending_ff) begin
               res_ff.status       <= lltd_pkg::ST_NO_JOB;
               res_ff.worker_index <= lltd_pkg::WIDX_W'(bw_ff);
               res_ff.worker_load  <= lltd_pkg::WLOAD_W'(bld_ff);
            end else begin
               res_ff.status           <= lltd_pkg::ST_OK;
               res_ff.worker_index     <= lltd_pkg::WIDX_W'(bw_ff);
               res_ff.out_job_id       <= jid_ff;
               res_ff.out_job_priority <= jprio_ff;
               res_ff.worker_load      <= lltd_pkg::WLOAD_W'(bld_ff + LW'(1));
            end
         end
         lltd_pkg::S_RES_END: begin
            if (!found_ff) begin
               res_ff.status <= lltd_pkg::ST_NOTHING;
            end
            s_ff <= bs_ff;
         end
         lltd_pkg::S_SH_EV: begin
            s_ff <= s_next;
         end
         lltd_pkg::S_FIN_WR: begin
            res_ff.status           <= lltd_pkg::ST_OK;
            res_ff.worker_index     <= lltd_pkg::WIDX_W'(bw_ff);
            res_ff.out_job_id       <= bid_ff;
            res_ff.out_job_priority <= bp_ff;
            res_ff.worker_load      <= lltd_pkg::WLOAD_W'(bld_ff - LW'(1));
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.status           = out_ff.status;
   assign rsp_bus.worker_index     = out_ff.worker_index;
   assign rsp_bus.out_job_id       = out_ff.out_job_id;
   assign rsp_bus.out_job_priority = out_ff.out_job_priority;
   assign rsp_bus.worker_load      = out_ff.worker_load;

   // The worker table never grows past its size.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      wcount_ff <= WCW'(MAX_WORKERS))
      else $error("worker count beyond table size");

   // Load reads only address registered workers.
   a_worker_scan : assert property (@(posedge clock) disable iff (reset)
      state_ff == lltd_pkg::S_LD_RD |-> w_ff < wcount_ff)
      else $error("load scan beyond worker count");

   // A slot read stays below the load of the scanned worker.
   a_slot_scan : assert property (@(posedge clock) disable iff (reset)
      state_ff == lltd_pkg::S_SL_RD |-> s_ff < cld_ff)
      else $error("slot scan beyond worker load");

   // Shifting only happens behind a job that was actually found.
   a_shift_found : assert property (@(posedge clock) disable iff (reset)
      state_ff == lltd_pkg::S_SH_EV |-> found_ff && s_next < bld_ff)
      else $error("slot shift without a resolved job");

endmodule
